// ===== rtl/etpi_pkg.sv =====
package etpi_pkg;

   localparam int EDGE_TIME_W = 48;
   localparam int TICK_W      = 15;
   localparam int DEN_W       = 13;
   localparam int WORD_W      = 32;
   localparam int IDX_W       = 6;

   localparam logic [TICK_W-1:0] DUR_MAX        = 15'h7FFF;
   localparam logic [4:0]        TICK_SCALE     = 5'd25;
   localparam logic [8:0]        DIV_ZERO_VALUE = 9'd256;
   localparam logic [7:0]        DIV_MASK       = 8'hFF;

   typedef struct packed {
      logic [EDGE_TIME_W-1:0] edge_time;
      logic                   edge_level;
      logic                   final_edge;
   } req_type;

   typedef struct packed {
      logic [WORD_W-1:0] item_word;
      logic [IDX_W-1:0]  item_index;
      logic              capture_done;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   function automatic logic [WORD_W-1:0] pack_item(
      input logic [TICK_W-1:0] d0,
      input logic              l0,
      input logic [TICK_W-1:0] d1,
      input logic              l1
   );
      return {l1, d1, l0, d0};
   endfunction

   // divider 0 stands for 256, tick period is div*25 half-ns units
   function automatic logic [DEN_W-1:0] tick_denominator(input logic [7:0] divider);
      logic [8:0] div9;
      div9 = ((divider & DIV_MASK) == 8'd0) ? DIV_ZERO_VALUE : {1'b0, divider};
      return DEN_W'(div9 * TICK_SCALE);
   endfunction

endpackage

// ===== rtl/etpi_req_if.sv =====
interface etpi_req_if import etpi_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/etpi_rsp_if.sv =====
interface etpi_rsp_if import etpi_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/etpi_div.sv =====
module etpi_div import etpi_pkg::*; #(
   parameter int NUM_W = 49
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_W-1:0]    numer,
   input  logic [DEN_W-1:0]    denom,
   output logic                done,
   output logic [TICK_W-1:0]   ticks
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [TICK_W-1:0] quo_ff, quo_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;

   logic [DEN_W:0]    trial;
   logic [DEN_W:0]    diff;
   logic              fits;

   // one restoring step per cycle, one quotient bit per numerator bit
   assign trial = {rem_ff, num_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_comb begin
      num_in  = num_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      ovf_in  = ovf_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = numer;
         den_in  = denom;
         rem_in  = '0;
         quo_in  = '0;
         ovf_in  = 1'b0;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         rem_in = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         quo_in = {quo_ff[TICK_W-2:0], fits};
         // a bit pushed past the top means the tick count saturates
         ovf_in = ovf_ff | quo_ff[TICK_W-1];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done  = done_ff;
   assign ticks = ovf_ff ? DUR_MAX : quo_ff;

endmodule

// ===== rtl/edge_timeline_to_pulse_items.sv =====
// an edge after the first of a capture passes through the restoring divider in
// ST_DIVIDE, then its result words go one at a time to the output register in ST_EMIT
// a new edge is taken only in ST_IDLE, once the divider and the words of the last edge
// are done, so output stalls also hold off input; the first edge of a capture needs
// no divide and leaves the block ready
// reset: synchronous, active high; clears the divider, capture state and output valid
module edge_timeline_to_pulse_items import etpi_pkg::*; #(
   parameter int ITEMS_PER_CHANNEL = 64,
   parameter int TIME_BITS         = 48
) (
   input  logic       clock,
   input  logic       reset,
   etpi_req_if.sink   req_bus,
   etpi_rsp_if.source rsp_bus,
   input  logic       csr_write_enable,
   input  logic [7:0] csr_write_data
);

   localparam int CNT_W = $clog2(ITEMS_PER_CHANNEL + 1);
   localparam int NUM_W = TIME_BITS + 1;

   logic [7:0]             divider_ff;

   state_type              state_ff, state_in;
   logic [EDGE_TIME_W-1:0] prev_time_ff, prev_time_in;
   logic                   prev_level_ff, prev_level_in;
   logic                   seen_ff, seen_in;
   logic [TICK_W-1:0]      half_ticks_ff, half_ticks_in;
   logic                   half_level_ff, half_level_in;
   logic                   half_pending_ff, half_pending_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   level_ff, level_in;
   logic                   last_ff, last_in;
   logic [WORD_W-1:0]      word_ff [3];
   logic [WORD_W-1:0]      word_in [3];
   logic [1:0]             nword_ff, nword_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_data_ff, out_data_in;

   logic                   accept;
   logic                   div_start;
   logic                   div_done;
   logic [TICK_W-1:0]      ticks;
   logic [TIME_BITS+EDGE_TIME_W-1:0] now_ext, prev_ext;
   logic [TIME_BITS-1:0]   gap;
   logic [CNT_W+IDX_W-1:0] count_ext;
   logic                   out_free;

   assign now_ext   = {{TIME_BITS{1'b0}}, req_bus.data.edge_time};
   assign prev_ext  = {{TIME_BITS{1'b0}}, prev_time_ff};
   assign gap       = now_ext[TIME_BITS-1:0] - prev_ext[TIME_BITS-1:0];
   assign count_ext = {{IDX_W{1'b0}}, count_ff};
   assign out_free  = !out_valid_ff || rsp_bus.ready;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;
   assign div_start     = accept && seen_ff;

   etpi_div #(
      .NUM_W (NUM_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({gap, 1'b0}),
      .denom (tick_denominator(divider_ff)),
      .done  (div_done),
      .ticks (ticks)
   );

   always_comb begin
      state_in        = state_ff;
      prev_time_in    = prev_time_ff;
      prev_level_in   = prev_level_ff;
      seen_in         = seen_ff;
      half_ticks_in   = half_ticks_ff;
      half_level_in   = half_level_ff;
      half_pending_in = half_pending_ff;
      count_in        = count_ff;
      level_in        = level_ff;
      last_in         = last_ff;
      word_in         = word_ff;
      nword_in        = nword_ff;
      out_valid_in    = out_valid_ff && !rsp_bus.ready;
      out_data_in     = out_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               level_in = req_bus.data.edge_level;
               last_in  = req_bus.data.final_edge;
               if (seen_ff) begin
                  // the divider takes the gap at this edge, so the new time is kept now
                  prev_time_in = req_bus.data.edge_time;
                  state_in     = ST_DIVIDE;
               end else if (req_bus.data.final_edge) begin
                  prev_time_in  = '0;
                  prev_level_in = 1'b0;
                  seen_in       = 1'b0;
               end else begin
                  prev_time_in  = req_bus.data.edge_time;
                  prev_level_in = req_bus.data.edge_level;
                  seen_in       = 1'b1;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               word_in[2] = '0;
               if (!half_pending_ff) begin
                  word_in[0]      = pack_item(ticks, prev_level_ff, '0, level_ff);
                  word_in[1]      = '0;
                  nword_in        = last_ff ? 2'd2 : 2'd0;
                  half_ticks_in   = ticks;
                  half_level_in   = prev_level_ff;
                  half_pending_in = 1'b1;
               end else begin
                  word_in[0]      = pack_item(half_ticks_ff, half_level_ff, ticks,
                                              prev_level_ff);
                  word_in[1]      = pack_item(ticks, level_ff, '0, 1'b0);
                  nword_in        = last_ff ? 2'd3 : 2'd1;
                  half_pending_in = 1'b0;
               end
               if (last_ff) begin
                  prev_time_in    = '0;
                  prev_level_in   = 1'b0;
                  seen_in         = 1'b0;
                  half_ticks_in   = '0;
                  half_level_in   = 1'b0;
                  half_pending_in = 1'b0;
               end else begin
                  prev_level_in = level_ff;
                  seen_in       = 1'b1;
               end
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            priority if (nword_ff == 2'd0) begin
               if (last_ff) begin
                  count_in = '0;
               end
               state_in = ST_IDLE;
            end else if (count_ff >= CNT_W'(ITEMS_PER_CHANNEL)) begin
               // item memory full: word dropped
               word_in[0] = word_ff[1];
               word_in[1] = word_ff[2];
               nword_in   = nword_ff - 1'b1;
            end else if (out_free) begin
               out_valid_in             = 1'b1;
               out_data_in.item_word    = word_ff[0];
               out_data_in.item_index   = count_ext[IDX_W-1:0];
               out_data_in.capture_done = last_ff && ((nword_ff == 2'd1) ||
                  (count_ff == CNT_W'(ITEMS_PER_CHANNEL - 1)));
               word_in[0] = word_ff[1];
               word_in[1] = word_ff[2];
               nword_in   = nword_ff - 1'b1;
               count_in   = count_ff + 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         divider_ff      <= '0;
         state_ff        <= ST_IDLE;
         prev_time_ff    <= '0;
         prev_level_ff   <= 1'b0;
         seen_ff         <= 1'b0;
         half_ticks_ff   <= '0;
         half_level_ff   <= 1'b0;
         half_pending_ff <= 1'b0;
         count_ff        <= '0;
         nword_ff        <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            divider_ff <= csr_write_data;
         end
         state_ff        <= state_in;
         prev_time_ff    <= prev_time_in;
         prev_level_ff   <= prev_level_in;
         seen_ff         <= seen_in;
         half_ticks_ff   <= half_ticks_in;
         half_level_ff   <= half_level_in;
         half_pending_ff <= half_pending_in;
         count_ff        <= count_in;
         nword_ff        <= nword_in;
         out_valid_ff    <= out_valid_in;
      end
      level_ff    <= level_in;
      last_ff     <= last_in;
      word_ff     <= word_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid = out_valid_ff;
   assign rsp_bus.data  = out_data_ff;

endmodule

// ===== test/edge_timeline_to_pulse_items_test.sv =====
module edge_timeline_to_pulse_items_test;
   import etpi_pkg::*;

   localparam int ITEM_LIMIT    = 64;
   localparam int SETTLE_CYCLES = 80;
   localparam int QUIET_LIMIT   = 4000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [7:0] csr_write_data;

   etpi_req_if req_bus ();
   etpi_rsp_if rsp_bus ();

   edge_timeline_to_pulse_items u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // capture state as the block should hold it
   logic [7:0]  tick_divider;
   logic [47:0] last_edge_time;
   logic        last_level;
   logic        capture_open;
   logic [14:0] held_ticks;
   logic        held_level;
   logic        half_held;
   int          words_in_capture;

   rsp_type item_writes_due[$];
   rsp_type step_words[3];
   int      step_count;
   rsp_type oldest_due;

   int error_count;
   int quiet_cycles;
   int sender_idle_pct;
   int receiver_idle_pct;

   // timeline the stimulus walks along
   logic [47:0] timeline_now;
   logic        timeline_level;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] tick_period(input logic [7:0] div);
      return ((div == 8'd0) ? 64'd256 : {56'd0, div}) * 64'd25;
   endfunction

   function automatic logic [14:0] ticks_for_gap(input logic [47:0] gap,
                                                 input logic [7:0] div);
      logic [63:0] den;
      logic [63:0] q;
      logic [63:0] r;
      logic [63:0] t;
      den = tick_period(div);
      q = {16'd0, gap} / den;
      r = {16'd0, gap} % den;
      if (q >= 64'h4000) return 15'h7FFF;
      // half-ns units: round the doubled quotient up on the remainder
      t = 2 * q + (((2 * r) >= den) ? 64'd1 : 64'd0);
      if (t > 64'h7FFF) return 15'h7FFF;
      return t[14:0];
   endfunction

   function automatic void add_word(input logic [31:0] word);
      if (words_in_capture < ITEM_LIMIT && step_count < 3) begin
         step_words[step_count].item_word = word;
         step_words[step_count].item_index = words_in_capture[5:0];
         step_words[step_count].capture_done = 1'b0;
         words_in_capture++;
         step_count++;
      end
   endfunction

   function automatic void clear_capture();
      last_edge_time = '0;
      last_level = 1'b0;
      capture_open = 1'b0;
      held_ticks = '0;
      held_level = 1'b0;
      half_held = 1'b0;
      words_in_capture = 0;
   endfunction

   function automatic void predict_edge(input req_type e);
      logic [14:0] ticks;
      int i;
      step_count = 0;
      if (capture_open) begin
         ticks = ticks_for_gap(e.edge_time - last_edge_time, tick_divider);
         if (!half_held) begin
            held_ticks = ticks;
            held_level = last_level;
            half_held = 1'b1;
            if (e.final_edge) add_word({e.edge_level, 15'd0, held_level, held_ticks});
         end else begin
            add_word({last_level, ticks, held_level, held_ticks});
            half_held = 1'b0;
            // odd edge count: last pulse repeated with the final level
            if (e.final_edge) add_word({16'd0, e.edge_level, ticks});
         end
         if (e.final_edge) begin
            add_word(32'd0);
            if (step_count > 0) step_words[step_count-1].capture_done = 1'b1;
         end
      end
      for (i = 0; i < step_count; i++) item_writes_due.push_back(step_words[i]);
      if (e.final_edge) begin
         clear_capture();
      end else begin
         last_edge_time = e.edge_time;
         last_level = e.edge_level;
         capture_open = 1'b1;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (item_writes_due.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item beat, expected none, actual word %h index %0d done %b",
                     $time, rsp_bus.data.item_word, rsp_bus.data.item_index,
                     rsp_bus.data.capture_done);
         end else begin
            oldest_due = item_writes_due.pop_front();
            if (rsp_bus.data.item_word !== oldest_due.item_word) begin
               error_count++;
               $display("%0t: item_word expected %h actual %h", $time,
                        oldest_due.item_word, rsp_bus.data.item_word);
            end
            if (rsp_bus.data.item_index !== oldest_due.item_index) begin
               error_count++;
               $display("%0t: item_index expected %0d actual %0d", $time,
                        oldest_due.item_index, rsp_bus.data.item_index);
            end
            if (rsp_bus.data.capture_done !== oldest_due.capture_done) begin
               error_count++;
               $display("%0t: capture_done expected %b actual %b", $time,
                        oldest_due.capture_done, rsp_bus.data.capture_done);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          csr_write_enable) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("edge_timeline_to_pulse_items verification failed");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
   end

   task automatic send_edge(input logic [47:0] t, input logic lvl, input logic fin);
      req_type beat;
      beat.edge_time = t;
      beat.edge_level = lvl;
      beat.final_edge = fin;
      @(negedge clock);
      while ($urandom_range(99, 0) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.data <= beat;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_edge(beat);
      timeline_now = t;
      timeline_level = lvl;
   endtask

   task automatic settle_block();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (item_writes_due.size() != 0) @(posedge clock);
      // a non-final edge may give no result but may still sit in the divider
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_divider(input logic [7:0] value);
      settle_block();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      tick_divider = value;
   endtask

   function automatic logic [47:0] random_gap();
      logic [63:0] den;
      logic [63:0] wide;
      int pick;
      den = tick_period(tick_divider);
      pick = $urandom_range(99, 0);
      if (pick < 40) return 48'($urandom_range(32'(4 * den), 0));
      if (pick < 60) return 48'($urandom_range(32'h10_0000, 0));
      // around the point where the tick count saturates
      if (pick < 72) return 48'(64'h3FFF * den + $urandom_range(32'(2 * den), 0));
      if (pick < 84) begin
         return 48'($urandom_range(100, 0) * den + (den + 1) / 2 - $urandom_range(1, 0));
      end
      if (pick < 93) begin
         wide = {$urandom, $urandom};
         return wide[47:0];
      end
      return 48'd0;
   endfunction

   task automatic send_capture(input int edges);
      logic [47:0] t;
      logic lvl;
      int k;
      for (k = 0; k < edges; k++) begin
         t = timeline_now + random_gap();
         lvl = ($urandom_range(99, 0) < 80) ? ~timeline_level : 1'($urandom);
         send_edge(t, lvl, k == edges - 1);
      end
   endtask

   task automatic test_short_captures();
      send_edge(48'd500, 1'b1, 1'b1);      // lone final edge
      send_edge(48'd1000, 1'b1, 1'b0);
      send_edge(48'd20000, 1'b0, 1'b1);
      send_edge(48'd0, 1'b0, 1'b0);        // odd count: word, extra, marker
      send_edge(48'd64000, 1'b1, 1'b0);
      send_edge(48'd70000, 1'b0, 1'b1);
      send_edge(48'd100, 1'b1, 1'b0);
      send_edge(48'd6500, 1'b0, 1'b0);
      send_edge(48'd12900, 1'b1, 1'b0);
      send_edge(48'd40000, 1'b0, 1'b1);
   endtask

   task automatic test_tick_rounding();
      logic [47:0] t;
      t = 48'd0;
      send_edge(t, 1'b1, 1'b0);
      t = t + 48'd3199;
      send_edge(t, 1'b0, 1'b0);
      t = t + 48'd3200;                    // exactly half a tick rounds up
      send_edge(t, 1'b1, 1'b0);
      send_edge(t, 1'b0, 1'b0);            // zero gap
      t = t + 48'(16383 * 6400 + 6399);
      send_edge(t, 1'b1, 1'b0);
      t = t + 48'(16384 * 6400);
      send_edge(t, 1'b1, 1'b0);
      send_edge(t + 48'd1, 1'b0, 1'b1);
   endtask

   task automatic test_time_extremes();
      send_edge(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      send_edge(48'd0, 1'b0, 1'b0);        // wraps to a gap of one
      send_edge(48'hFFFF_FFFF_FFFF, 1'b1, 1'b0);
      send_edge(48'h7FFF_FFFF_FFFF, 1'b0, 1'b1);
   endtask

   task automatic test_divider_extremes();
      write_divider(8'd1);
      send_edge(48'd0, 1'b1, 1'b0);
      send_edge(48'd37, 1'b0, 1'b0);
      send_edge(48'd100, 1'b1, 1'b1);
      write_divider(8'd255);
      send_edge(48'd0, 1'b0, 1'b0);
      send_edge(48'd22312, 1'b1, 1'b1);
   endtask

   task automatic test_random_traffic(input int phase, input int budget);
      int sent;
      int len;
      int pick;
      bit rewritten;
      sent = 0;
      rewritten = 1'b0;
      sender_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 76 : 0;
      receiver_idle_pct = (phase == 0) ? 76 : (phase == 1) ? 20 : 0;
      write_divider(8'($urandom_range(255, 0)));
      // one capture long enough to run into the item limit
      if (phase == 2) begin
         len = $urandom_range(134, 126);
         send_capture(len);
         sent += len;
      end
      while (sent < budget) begin
         if (!rewritten && sent >= budget / 2) begin
            write_divider(8'($urandom_range(255, 0)));
            rewritten = 1'b1;
         end
         pick = $urandom_range(99, 0);
         len = (pick < 8) ? 1 : (pick < 18) ? 2 : $urandom_range(10, 2);
         send_capture(len);
         sent += len;
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data = 8'd0;
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      rsp_bus.ready = 1'b0;
      error_count = 0;
      quiet_cycles = 0;
      sender_idle_pct = 20;
      receiver_idle_pct = 76;
      tick_divider = 8'd0;
      timeline_now = '0;
      timeline_level = 1'b0;
      clear_capture();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_captures();
      test_tick_rounding();
      test_time_extremes();
      test_divider_extremes();
      test_random_traffic(0, 150);
      test_random_traffic(1, 150);
      test_random_traffic(2, 160);
      settle_block();

      if (error_count == 0) begin
         $display("edge_timeline_to_pulse_items verification clean");
      end else begin
         $display("edge_timeline_to_pulse_items verification failed");
      end
      $finish;
   end

endmodule
